[src/hcgv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcgv_pkg
// Shared types, constants and the CORDIC arctangent table for the circle
// Hough gradient voting block.
// ----------------------------------------------------------------------------
package hcgv_pkg;

    localparam int CORDIC_ITERS = 16;
    localparam int MAX_OUT      = 32;

    typedef logic signed [19:0] cord_t;
    typedef logic signed [15:0] trig_t;
    typedef logic        [2:0]  cfg_idx_t;

    localparam logic signed [16:0] ANG_PI      = 17'sd25736;
    localparam logic signed [16:0] ANG_HALF_PI = 17'sd12868;
    localparam cord_t              CORDIC_GAIN = 20'sd19899;
    localparam cord_t              TRIG_MAX    = 20'sd32767;

    localparam cfg_idx_t REG_EDGE_THR  = 3'd0;
    localparam cfg_idx_t REG_VOTE_THR  = 3'd1;
    localparam cfg_idx_t REG_MIN_RAD   = 3'd2;
    localparam cfg_idx_t REG_RAD_CNT   = 3'd3;
    localparam cfg_idx_t REG_ACT_W     = 3'd4;
    localparam cfg_idx_t REG_ACT_H     = 3'd5;

    // atan(2^-i) in units of 2^-16 rad
    function automatic cord_t atan_lut(input logic [3:0] i);
        cord_t r;
        case (i)
            4'd0:    r = 20'sd51472;
            4'd1:    r = 20'sd30386;
            4'd2:    r = 20'sd16055;
            4'd3:    r = 20'sd8150;
            4'd4:    r = 20'sd4091;
            4'd5:    r = 20'sd2047;
            4'd6:    r = 20'sd1024;
            4'd7:    r = 20'sd512;
            4'd8:    r = 20'sd256;
            4'd9:    r = 20'sd128;
            4'd10:   r = 20'sd64;
            4'd11:   r = 20'sd32;
            4'd12:   r = 20'sd16;
            4'd13:   r = 20'sd8;
            4'd14:   r = 20'sd4;
            4'd15:   r = 20'sd2;
            default: r = 20'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[src/hcgv_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcgv_if
// Valid/ready channels for pixel beats and candidate beats.
// ----------------------------------------------------------------------------
interface hcgv_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic        [5:0]  pix_x;
    logic        [5:0]  pix_y;
    logic        [7:0]  edge_value;
    logic signed [15:0] grad_angle;

    modport source (output valid, action, pix_x, pix_y, edge_value, grad_angle,
                    input ready);
    modport sink   (input valid, action, pix_x, pix_y, edge_value, grad_angle,
                    output ready);
endinterface

interface hcgv_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  cand_x;
    logic [5:0]  cand_y;
    logic [10:0] cand_radius;
    logic        last;

    modport source (output valid, cand_x, cand_y, cand_radius, last, input ready);
    modport sink   (input valid, cand_x, cand_y, cand_radius, last, output ready);
endinterface
`default_nettype wire

[src/hough_circle_gradient_vote.sv]
// A voting pixel first waits on CORDIC (16 iterations in one shared shift-add
// unit); then each radius offset is scaled in S_MUL and voted on both sides
// of the pixel, where in bounds, by a read-modify-write (S_RD, S_UPD) through
// the separate read and write ports of the vote RAM; S_FIN closes the beat.
// One pixel at a time; weak pixels are taken without voting.
// Reset and every clear beat sweep all 2^(clog2(H)+clog2(W)+clog2(R)) cells
// of the vote RAM (65536 by default), one cell per cycle, ready low meanwhile.
`default_nettype none
// ----------------------------------------------------------------------------
// hough_circle_gradient_vote
// Gradient-directed circle Hough voting with a sequenced read-modify-write
// vote store and candidate output.
// ----------------------------------------------------------------------------
module hough_circle_gradient_vote
    import hcgv_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 64,
    parameter int IMAGE_HEIGHT = 64,
    parameter int RADIUS_DEPTH = 16,
    parameter int COUNT_BITS   = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_we,
    input  wire cfg_idx_t cfg_index,
    input  wire logic [15:0] cfg_data,
    hcgv_in_if.sink       pix_in,
    hcgv_out_if.source    cand_out
);

    localparam int XB    = $clog2(IMAGE_WIDTH);
    localparam int YB    = $clog2(IMAGE_HEIGHT);
    localparam int RB    = $clog2(RADIUS_DEPTH);
    localparam int AW    = XB + YB + RB;
    localparam int DEPTH = 1 << AW;
    localparam int CMPW  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CORD = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic [7:0]  edge_thr_reg;
    logic [15:0] vote_thr_reg;
    logic [9:0]  min_rad_reg;
    logic [4:0]  rad_cnt_reg;
    logic [6:0]  act_w_reg;
    logic [6:0]  act_h_reg;

    logic [5:0]  px_reg, px_next;
    logic [5:0]  py_reg, py_next;
    trig_t       c_reg, c_next;
    trig_t       s_reg, s_next;
    logic [4:0]  off_reg, off_next;
    logic        side_reg, side_next;
    logic signed [21:0] rc_reg, rc_next;
    logic signed [21:0] rs_reg, rs_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [5:0]  cx_reg, cx_next;
    logic [5:0]  cy_reg, cy_next;
    logic [5:0]  n_reg, n_next;

    logic        pend_v_reg, pend_v_next;
    logic [5:0]  pend_x_reg, pend_x_next;
    logic [5:0]  pend_y_reg, pend_y_next;
    logic [10:0] pend_r_reg, pend_r_next;

    logic        out_v_reg, out_v_next;
    logic [5:0]  out_x_reg, out_x_next;
    logic [5:0]  out_y_reg, out_y_next;
    logic [10:0] out_r_reg, out_r_next;
    logic        out_l_reg, out_l_next;

    logic        cord_start, cord_done;
    trig_t       cord_cos, cord_sin;

    logic        ram_we, ram_re;
    logic [AW-1:0] ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, vinc;

    logic signed [22:0] sx, sy;
    logic [6:0]  cx7, cy7;
    logic        in_bounds, cand, out_full, take;

    hcgv_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .angle   (pix_in.grad_angle),
        .done    (cord_done),
        .cos_out (cord_cos),
        .sin_out (cord_sin)
    );

    hcgv_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_next),
        .rdata (ram_rdata)
    );

    assign pix_in.ready         = (state_reg == S_IDLE);
    assign take                 = pix_in.valid && pix_in.ready;
    assign cand_out.valid       = out_v_reg;
    assign cand_out.cand_x      = out_x_reg;
    assign cand_out.cand_y      = out_y_reg;
    assign cand_out.cand_radius = out_r_reg;
    assign cand_out.last        = out_l_reg;
    assign out_full             = out_v_reg && !cand_out.ready;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        c_next        = c_reg;
        s_next        = s_reg;
        off_next      = off_reg;
        side_next     = side_reg;
        rc_next       = rc_reg;
        rs_next       = rs_reg;
        addr_next     = addr_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        n_next        = n_reg;
        pend_v_next   = pend_v_reg;
        pend_x_next   = pend_x_reg;
        pend_y_next   = pend_y_reg;
        pend_r_next   = pend_r_reg;
        out_v_next    = out_v_reg && !cand_out.ready;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_r_next    = out_r_reg;
        out_l_next    = out_l_reg;
        cord_start    = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = '0;

        if (side_reg)
        begin
            sx = $signed({2'b00, px_reg, 15'd0}) - 23'(rc_reg);
            sy = $signed({2'b00, py_reg, 15'd0}) - 23'(rs_reg);
        end
        else
        begin
            sx = $signed({2'b00, px_reg, 15'd0}) + 23'(rc_reg);
            sy = $signed({2'b00, py_reg, 15'd0}) + 23'(rs_reg);
        end
        cx7 = sx[21:15];
        cy7 = sy[21:15];
        in_bounds = !sx[22] && (sx != 0) && !sy[22] && (sy != 0)
                    && (cx7 != 0) && (cy7 != 0)
                    && (cx7 < act_w_reg) && (32'(cx7) < IMAGE_WIDTH)
                    && (cy7 < act_h_reg) && (32'(cy7) < IMAGE_HEIGHT);

        vinc = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
        cand = (CMPW'(vinc) > CMPW'(vote_thr_reg)) && (n_reg < 6'(MAX_OUT));

        case (state_reg)
            S_CLR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    px_next   = pix_in.pix_x;
                    py_next   = pix_in.pix_y;
                    off_next  = 5'd1;
                    side_next = 1'b0;
                    n_next    = '0;
                    if (pix_in.action)
                    begin
                        clr_addr_next = '0;
                        state_next    = S_CLR;
                    end
                    else if (pix_in.edge_value > edge_thr_reg)
                    begin
                        cord_start = 1'b1;
                        state_next = S_CORD;
                    end
                end
            end
            S_CORD:
            begin
                if (cord_done)
                begin
                    c_next     = cord_cos;
                    s_next     = cord_sin;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                rc_next   = 22'($signed({1'b0, off_reg}) * c_reg);
                rs_next   = 22'($signed({1'b0, off_reg}) * s_reg);
                side_next = 1'b0;
                if ((off_reg < rad_cnt_reg) && (32'(off_reg) < RADIUS_DEPTH))
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_RD:
            begin
                if (in_bounds)
                begin
                    ram_re     = 1'b1;
                    addr_next  = {YB'(cy7), XB'(cx7), RB'(off_reg)};
                    cx_next    = cx7[5:0];
                    cy_next    = cy7[5:0];
                    state_next = S_UPD;
                end
                else if (!side_reg)
                begin
                    side_next = 1'b1;
                end
                else
                begin
                    off_next   = off_reg + 5'd1;
                    state_next = S_MUL;
                end
            end
            S_UPD:
            begin
                if (!(cand && pend_v_reg && out_full))
                begin
                    ram_we    = 1'b1;
                    ram_wdata = vinc;
                    if (cand)
                    begin
                        if (pend_v_reg)
                        begin
                            out_v_next = 1'b1;
                            out_x_next = pend_x_reg;
                            out_y_next = pend_y_reg;
                            out_r_next = pend_r_reg;
                            out_l_next = 1'b0;
                        end
                        pend_v_next = 1'b1;
                        pend_x_next = cx_reg;
                        pend_y_next = cy_reg;
                        pend_r_next = 11'(min_rad_reg) + 11'(off_reg);
                        n_next      = n_reg + 6'd1;
                    end
                    if (!side_reg)
                    begin
                        side_next  = 1'b1;
                        state_next = S_RD;
                    end
                    else
                    begin
                        off_next   = off_reg + 5'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_FIN:
            begin
                if (!pend_v_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_full)
                begin
                    out_v_next  = 1'b1;
                    out_x_next  = pend_x_reg;
                    out_y_next  = pend_y_reg;
                    out_r_next  = pend_r_reg;
                    out_l_next  = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_addr_reg <= '0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
            n_reg        <= '0;
            edge_thr_reg <= 8'd0;
            vote_thr_reg <= 16'd8;
            min_rad_reg  <= 10'd5;
            rad_cnt_reg  <= 5'd10;
            act_w_reg    <= 7'd64;
            act_h_reg    <= 7'd64;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_v_reg   <= pend_v_next;
            out_v_reg    <= out_v_next;
            n_reg        <= n_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EDGE_THR: edge_thr_reg <= cfg_data[7:0];
                    REG_VOTE_THR: vote_thr_reg <= cfg_data;
                    REG_MIN_RAD:  min_rad_reg  <= cfg_data[9:0];
                    REG_RAD_CNT:  rad_cnt_reg  <= cfg_data[4:0];
                    REG_ACT_W:    act_w_reg    <= cfg_data[6:0];
                    REG_ACT_H:    act_h_reg    <= cfg_data[6:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        c_reg      <= c_next;
        s_reg      <= s_next;
        off_reg    <= off_next;
        side_reg   <= side_next;
        rc_reg     <= rc_next;
        rs_reg     <= rs_next;
        addr_reg   <= addr_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        pend_x_reg <= pend_x_next;
        pend_y_reg <= pend_y_next;
        pend_r_reg <= pend_r_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_r_reg  <= out_r_next;
        out_l_reg  <= out_l_next;
    end

`ifndef SYNTHESIS
    a_upd_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |-> $past(state_reg) == S_RD || $past(state_reg) == S_UPD)
        else $error("vote update without read");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pix_in.ready |-> !ram_we)
        else $error("store written while idle");
    a_cand_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= 6'(MAX_OUT))
        else $error("candidate count overrun");
    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        cord_done |-> state_reg == S_CORD)
        else $error("cordic result outside wait state");
`endif

endmodule
`default_nettype wire

[src/hcgv_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcgv_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hcgv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[src/hcgv_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcgv_cordic
// Iterative rotation CORDIC, one micro-rotation per cycle, Q1.15 cos/sin.
// ----------------------------------------------------------------------------
module hcgv_cordic
    import hcgv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire trig_t angle,
    output logic       done,
    output trig_t      cos_out,
    output trig_t      sin_out
);

    logic        busy_reg, busy_next;
    logic        fin_reg, fin_next;
    logic [3:0]  it_reg, it_next;
    logic        neg_reg, neg_next;
    cord_t       x_reg, x_next;
    cord_t       y_reg, y_next;
    cord_t       z_reg, z_next;

    logic signed [16:0] a17;
    logic signed [16:0] ared;
    logic               aneg;
    cord_t              xs, ys, xsat, ysat;

    always_comb
    begin
        a17  = 17'(angle);
        aneg = 1'b0;
        ared = a17;
        if (a17 > ANG_HALF_PI)
        begin
            ared = a17 - ANG_PI;
            aneg = 1'b1;
        end
        else if (a17 < -ANG_HALF_PI)
        begin
            ared = a17 + ANG_PI;
            aneg = 1'b1;
        end

        xs = x_reg >>> it_reg;
        ys = y_reg >>> it_reg;

        busy_next = busy_reg;
        fin_next  = 1'b0;
        it_next   = it_reg;
        neg_next  = neg_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;

        if (start)
        begin
            busy_next = 1'b1;
            it_next   = '0;
            neg_next  = aneg;
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = 20'(ared) <<< 3;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_lut(it_reg);
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_lut(it_reg);
            end
            it_next = it_reg + 4'd1;
            if (it_reg == 4'(CORDIC_ITERS - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end

        xsat = x_reg;
        if (x_reg > TRIG_MAX)
        begin
            xsat = TRIG_MAX;
        end
        else if (x_reg < -TRIG_MAX)
        begin
            xsat = -TRIG_MAX;
        end
        ysat = y_reg;
        if (y_reg > TRIG_MAX)
        begin
            ysat = TRIG_MAX;
        end
        else if (y_reg < -TRIG_MAX)
        begin
            ysat = -TRIG_MAX;
        end
        if (neg_reg)
        begin
            xsat = -xsat;
            ysat = -ysat;
        end
    end

    assign done    = fin_reg;
    assign cos_out = 16'(xsat);
    assign sin_out = 16'(ysat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg))
        else $error("cordic done without iteration");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |=> busy_reg || fin_reg)
        else $error("cordic dropped busy without finishing");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("cordic done longer than one cycle");
`endif

endmodule
`default_nettype wire
